// ===== sv/lbfpc_pkg.sv =====
`default_nettype none

package lbfpc_pkg;

  localparam int MaxLevel = 100;
  localparam int LevelW = $clog2(MaxLevel + 1);
  localparam int SlotW = $clog2(MaxLevel);
  localparam int OutLevelW = 7;
  localparam int TicksW = 16;
  localparam int ModeW = 3;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 16;

  localparam logic [TicksW-1:0] OnTicksRst = TicksW'(500);
  localparam logic [TicksW-1:0] OffTicksRst = TicksW'(500);
  localparam logic [TicksW-1:0] FadeIntervalRst = TicksW'(10);
  localparam logic [TicksW-1:0] ElapsedMax = {TicksW{1'b1}};

  typedef enum logic [ModeW-1:0] {
    ModeOff     = 3'd0,
    ModeOn      = 3'd1,
    ModeBlink   = 3'd2,
    ModeFadeIn  = 3'd3,
    ModeFadeOut = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode         = 8'd0,
    RegOnTicks      = 8'd1,
    RegOffTicks     = 8'd2,
    RegFadeInterval = 8'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== sv/led_blink_fade_pwm_controller.sv =====
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_stall_o   | tick_i
// out      | output    | out_valid_o / out_stall_i | pin_level_o, level_now_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each input beat updates the LED state in the cycle it is taken; its result is registered
// in the output or skid register; one beat per clock is taken while in_stall_o is low.
// A two-entry output stage (output register plus skid register) sets the rate.
// in_stall_o is high while the skid register is full or a configuration write is offered.
// Reset is asynchronous and active low; it clears the valid flags, modes and counters.
// Configuration writes are always ready and take effect in the next cycle.
`default_nettype none

module led_blink_fade_pwm_controller
  import lbfpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 tick_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      pin_level_o,
  output logic [OutLevelW-1:0]      level_now_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  mode_e              mode_q, mode_d;
  logic [TicksW-1:0]  on_ticks_q, on_ticks_d;
  logic [TicksW-1:0]  off_ticks_q, off_ticks_d;
  logic [TicksW-1:0]  fade_interval_q, fade_interval_d;

  logic [LevelW-1:0]  brightness_q, brightness_d;
  logic               lit_phase_q, lit_phase_d;
  logic [TicksW-1:0]  elapsed_q, elapsed_d;
  logic [SlotW-1:0]   pwm_slot_q, pwm_slot_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_pin_q, out_pin_d;
  logic [OutLevelW-1:0] out_level_q, out_level_d;
  logic                 skid_valid_q, skid_valid_d;
  logic                 skid_pin_q, skid_pin_d;
  logic [OutLevelW-1:0] skid_level_q, skid_level_d;

  logic               in_fire, out_fire, cfg_fire;
  logic [TicksW-1:0]  elapsed_inc, target;
  logic [SlotW-1:0]   slot_inc;
  logic               apply_mode;
  mode_e              mode_new;
  logic               res_pin;
  logic [OutLevelW-1:0] res_level;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = skid_valid_q | cfg_valid_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;

  assign elapsed_inc = (elapsed_q != ElapsedMax) ? elapsed_q + TicksW'(1) : elapsed_q;
  assign slot_inc    = (pwm_slot_q == SlotW'(MaxLevel - 1)) ? '0 : pwm_slot_q + SlotW'(1);
  assign target      = lit_phase_q ? on_ticks_q : off_ticks_q;

  always_comb begin
    mode_d          = mode_q;
    on_ticks_d      = on_ticks_q;
    off_ticks_d     = off_ticks_q;
    fade_interval_d = fade_interval_q;
    brightness_d    = brightness_q;
    lit_phase_d     = lit_phase_q;
    elapsed_d       = elapsed_q;
    pwm_slot_d      = pwm_slot_q;
    apply_mode      = 1'b0;
    mode_new        = mode_q;

    if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMode: begin
          mode_new = mode_e'(cfg_data_i[ModeW-1:0]);
          if (mode_new != mode_q) begin
            mode_d     = mode_new;
            apply_mode = 1'b1;
          end
        end
        RegOnTicks: begin
          if (cfg_data_i != on_ticks_q) begin
            on_ticks_d = cfg_data_i;
            apply_mode = 1'b1;
          end
        end
        RegOffTicks: begin
          if (cfg_data_i != off_ticks_q) begin
            off_ticks_d = cfg_data_i;
            apply_mode  = 1'b1;
          end
        end
        RegFadeInterval: fade_interval_d = cfg_data_i;
        default: ;
      endcase

      if (apply_mode) begin
        elapsed_d = '0;
        unique case (mode_new)
          ModeOff: brightness_d = '0;
          ModeOn:  brightness_d = LevelW'(MaxLevel);
          ModeBlink: begin
            brightness_d = LevelW'(MaxLevel);
            lit_phase_d  = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (in_fire && tick_i) begin
      elapsed_d  = elapsed_inc;
      pwm_slot_d = slot_inc;
      unique case (mode_q)
        ModeBlink: begin
          if (elapsed_inc >= target) begin
            elapsed_d    = '0;
            lit_phase_d  = ~lit_phase_q;
            brightness_d = lit_phase_q ? '0 : LevelW'(MaxLevel);
          end
        end
        ModeFadeIn: begin
          if (elapsed_inc >= fade_interval_q) begin
            elapsed_d = '0;
            if (brightness_q < LevelW'(MaxLevel)) begin
              brightness_d = brightness_q + LevelW'(1);
            end
          end
        end
        ModeFadeOut: begin
          if (elapsed_inc >= fade_interval_q) begin
            elapsed_d = '0;
            if (brightness_q != '0) begin
              brightness_d = brightness_q - LevelW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_pin   = ~(LevelW'(pwm_slot_d) < brightness_d);
  assign res_level = OutLevelW'(brightness_d);

  always_comb begin
    out_valid_d  = out_valid_q;
    out_pin_d    = out_pin_q;
    out_level_d  = out_level_q;
    skid_valid_d = skid_valid_q;
    skid_pin_d   = skid_pin_q;
    skid_level_d = skid_level_q;

    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pin_d    = skid_pin_q;
        out_level_d  = skid_level_q;
        skid_valid_d = 1'b0;
      end else if (in_fire) begin
        out_valid_d = 1'b1;
        out_pin_d   = res_pin;
        out_level_d = res_level;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_pin_d   = res_pin;
      skid_level_d = res_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= ModeOff;
      on_ticks_q      <= OnTicksRst;
      off_ticks_q     <= OffTicksRst;
      fade_interval_q <= FadeIntervalRst;
      brightness_q    <= '0;
      lit_phase_q     <= 1'b0;
      elapsed_q       <= '0;
      pwm_slot_q      <= '0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      mode_q          <= mode_d;
      on_ticks_q      <= on_ticks_d;
      off_ticks_q     <= off_ticks_d;
      fade_interval_q <= fade_interval_d;
      brightness_q    <= brightness_d;
      lit_phase_q     <= lit_phase_d;
      elapsed_q       <= elapsed_d;
      pwm_slot_q      <= pwm_slot_d;
      out_valid_q     <= out_valid_d;
      skid_valid_q    <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pin_q    <= out_pin_d;
    out_level_q  <= out_level_d;
    skid_pin_q   <= skid_pin_d;
    skid_level_q <= skid_level_d;
  end

  assign out_valid_o = out_valid_q;
  assign pin_level_o = out_pin_q;
  assign level_now_o = out_level_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a beat while the output register is empty.");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("An accepted input beat left no result in the output register.");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brightness_q <= LevelW'(MaxLevel))
    else $error("Brightness exceeds the maximum level.");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LevelW'(pwm_slot_q) < LevelW'(MaxLevel))
    else $error("PWM slot counter left its range.");

endmodule

`default_nettype wire
